@@ src/rdc_pkg.sv @@
// rdc_pkg: shared constants, types and the digit glyph function of the
// radix digit converter. No dependencies.
package rdc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int RADIX_W    = 5;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   // quotient bits resolved per cycle in the divider
   localparam int DIV_STEP   = 8;
   localparam int NUM_CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_W      = NUM_CHUNKS * DIV_STEP;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int SP_W       = $clog2(VALUE_BITS + 1);
   localparam int IDX_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55); // 'A' - 10

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_W-1:0]    base;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(d);
      if (d <= DIGIT_W'(9)) begin
         return CHAR_ZERO + ext;
      end
      return CHAR_LETTER + ext;
   endfunction

endpackage

@@ src/rdc_front.sv @@
// rdc_front: holds the radix register, saturates it and accepts request
// transactions into jobs. Depends on rdc_pkg.
module rdc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rdc_pkg::RADIX_W-1:0]   csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rdc_pkg::VALUE_BITS-1:0] req_value,
   output logic                          push,
   output rdc_pkg::job_type              push_job,
   input  logic                          queue_full
);
   import rdc_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic [RADIX_W-1:0] base_sat;

   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? csr_data : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         base_sat = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base_sat = RADIX_MAX;
      end else begin
         base_sat = radix_ff;
      end
   end

   assign req_stall      = queue_full;
   assign push           = req_valid && !queue_full;
   assign push_job.value = req_value;
   assign push_job.base  = base_sat;

endmodule

@@ src/rdc_queue.sv @@
// rdc_queue: two-entry job queue between front and back.
// Depends on rdc_pkg.
module rdc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rdc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output rdc_pkg::job_type pop_job
);
   import rdc_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/rdc_back.sv @@
// rdc_back: iterative divider, digit stack and response register.
// Depends on rdc_pkg.
module rdc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  rdc_pkg::job_type             job,
   output logic                         job_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rdc_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                         rsp_last_digit
);
   import rdc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_type;

   state_type            state_ff, state_in;
   logic [DIV_W-1:0]     dividend_ff, dividend_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   base_ff, base_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [DIGIT_W-1:0]   stack_ff [VALUE_BITS];
   logic                 push_digit;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [RADIX_W-1:0]   r_step;
   logic [DIV_W-1:0]     d_step;
   logic [DIV_W-1:0]     q_step;
   logic [SP_W-1:0]      sp_dec;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sp_dec   = sp_ff - SP_W'(1);
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   // restoring division, DIV_STEP quotient bits per cycle
   always_comb begin
      r_step = rem_ff;
      d_step = dividend_ff;
      q_step = quot_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         r_step = {r_step[RADIX_W-2:0], d_step[DIV_W-1]};
         d_step = {d_step[DIV_W-2:0], 1'b0};
         q_step = {q_step[DIV_W-2:0], (r_step >= base_ff)};
         if (r_step >= base_ff) begin
            r_step = r_step - base_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      dividend_in  = dividend_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      chunk_in     = chunk_ff;
      sp_in        = sp_ff;
      push_digit   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               dividend_in = DIV_W'(job.value);
               quot_in     = '0;
               rem_in      = '0;
               base_in     = job.base;
               chunk_in    = '0;
               sp_in       = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            dividend_in = d_step;
            quot_in     = q_step;
            rem_in      = r_step;
            chunk_in    = chunk_ff + CHUNK_W'(1);
            if (chunk_ff == CHUNK_W'(NUM_CHUNKS - 1)) begin
               push_digit  = 1'b1;
               sp_in       = sp_ff + SP_W'(1);
               dividend_in = q_step;
               quot_in     = '0;
               rem_in      = '0;
               chunk_in    = '0;
               if (q_step == '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_glyph(stack_ff[sp_dec[IDX_W-1:0]]);
               rsp_last_in  = (sp_ff == SP_W'(1));
               sp_in        = sp_dec;
               if (sp_ff == SP_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         chunk_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
         chunk_ff     <= chunk_in;
      end
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (push_digit) begin
         stack_ff[sp_ff[IDX_W-1:0]] <= r_step[DIGIT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

@@ src/radix_digit_converter.sv @@
// radix_digit_converter: top level; front, job queue and back.
// Depends on rdc_pkg, rdc_front, rdc_queue, rdc_back.
//
// Converts each req_value into ASCII digits in the base held in the csr
// register (reset 10, saturated into 2..16), sent most significant first
// with rsp_last_digit on the final digit; zero gives the single digit '0'.
// The back end divides by the base 8 quotient bits per cycle and works out
// every digit of a value before it sends the first. A two-entry queue
// takes up to two further request transactions while a conversion is in
// progress. Write csr only while idle.
module radix_digit_converter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rdc_pkg::RADIX_W-1:0]    csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rdc_pkg::VALUE_BITS-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rdc_pkg::CHAR_W-1:0]     rsp_digit_char,
   output logic                           rsp_last_digit
);
   import rdc_pkg::*;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   job_type pop_job;

   rdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   rdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   rdc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job            (pop_job),
      .job_pop        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

@@ src/rdc_checker.sv @@
// rdc_checker: port-level assertions for radix_digit_converter, bound to
// the top level. Depends on rdc_pkg.
module rdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_ready,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [rdc_pkg::CHAR_W-1:0]     rsp_digit_char,
   input logic                           rsp_last_digit
);
   import rdc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_digit_char) && $stable(rsp_last_digit))
      else $error("stalled response changed");

   a_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= CHAR_W'(48) && rsp_digit_char <= CHAR_W'(57)) ||
                    (rsp_digit_char >= CHAR_W'(65) && rsp_digit_char <= CHAR_W'(70)))
      else $error("response is not a digit character");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_ready)
      else $error("response valid after reset");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_ready      (csr_ready),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last_digit (rsp_last_digit)
);
